### src/psd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, types and constants of the point to segment distance core.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int CoordBits = 32;
  localparam int FracBits  = 32;
  localparam int DiffBits  = CoordBits + 1;
  localparam int MagBits   = CoordBits;
  localparam int ProdBits  = 2 * MagBits;
  localparam int SumBits   = ProdBits + 1;
  localparam int NumBits   = SumBits + 1;
  localparam int TBits     = FracBits + 1;
  localparam int OffBits   = DiffBits + 1;
  // The radicand is padded to an even width so the root digits pair up from bit 0.
  localparam int SqBits    = 2 * OffBits + 2;
  localparam int RootBits  = (SqBits + 1) / 2;
  localparam int DistBits  = 33;

  // Division stage payload: remainder, quotient so far and the operands.
  typedef struct packed {
    logic                       valid;
    logic [NumBits-1:0]         rem;
    logic [SumBits-1:0]         den;
    logic [TBits-1:0]           quo;
    logic signed [DiffBits-1:0] rx;
    logic signed [DiffBits-1:0] ry;
    logic signed [DiffBits-1:0] dx;
    logic signed [DiffBits-1:0] dy;
  } div_beat_t;

  // Square root stage payload.
  typedef struct packed {
    logic                valid;
    logic [SqBits-1:0]   rad;
    logic [RootBits+1:0] rem;
    logic [RootBits-1:0] root;
  } sqrt_beat_t;

endpackage
`default_nettype wire

### src/psd_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring division step of the projection fraction, registered.
// ----------------------------------------------------------------------------
module psd_div_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     en,
  input  wire psd_pkg::div_beat_t din,
  output psd_pkg::div_beat_t      dout
);

  psd_pkg::div_beat_t beat_r, beat_nxt;
  logic [psd_pkg::NumBits-1:0] shifted;

  // Shift the remainder, compare against the squared length, subtract.
  always_comb begin
    beat_nxt = din;
    shifted  = {din.rem[psd_pkg::NumBits-2:0], 1'b0};
    if (shifted >= {1'b0, din.den}) begin
      beat_nxt.rem = shifted - {1'b0, din.den};
      beat_nxt.quo = {din.quo[psd_pkg::TBits-2:0], 1'b1};
    end else begin
      beat_nxt.rem = shifted;
      beat_nxt.quo = {din.quo[psd_pkg::TBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r.valid <= din.valid;
    end
    if (en) begin
      beat_r.rem  <= beat_nxt.rem;
      beat_r.den  <= beat_nxt.den;
      beat_r.quo  <= beat_nxt.quo;
      beat_r.rx   <= beat_nxt.rx;
      beat_r.ry   <= beat_nxt.ry;
      beat_r.dx   <= beat_nxt.dx;
      beat_r.dy   <= beat_nxt.dy;
    end
  end

  assign dout = beat_r;

endmodule
`default_nettype wire

### src/psd_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module psd_sqrt_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire psd_pkg::sqrt_beat_t din,
  output psd_pkg::sqrt_beat_t      dout
);

  psd_pkg::sqrt_beat_t beat_r, beat_nxt;
  logic [psd_pkg::RootBits+1:0] trial;
  logic [psd_pkg::RootBits+1:0] cand;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    beat_nxt      = din;
    beat_nxt.rad  = {din.rad[psd_pkg::SqBits-3:0], 2'b00};
    trial = {din.rem[psd_pkg::RootBits-1:0], din.rad[psd_pkg::SqBits-1:psd_pkg::SqBits-2]};
    cand  = {din.root, 2'b01};
    if (trial >= cand) begin
      beat_nxt.rem  = trial - cand;
      beat_nxt.root = {din.root[psd_pkg::RootBits-2:0], 1'b1};
    end else begin
      beat_nxt.rem  = trial;
      beat_nxt.root = {din.root[psd_pkg::RootBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r.valid <= din.valid;
    end
    if (en) begin
      beat_r.rad  <= beat_nxt.rad;
      beat_r.rem  <= beat_nxt.rem;
      beat_r.root <= beat_nxt.root;
    end
  end

  assign dout = beat_r;

endmodule
`default_nettype wire

### src/point_segment_distance_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_segment_distance_core
// Distance from a query point to a line segment, one beat per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// A new query is taken every cycle while out_ready is high. Three input
// stages form the differences and dot products, a row of FracBits divider
// cells forms the projection fraction, three stages form the offset and its
// squared length, a row of RootBits square root cells takes the root, and a
// final output register saturates the distance.
// The whole pipe advances together; a stalled output holds every stage.
// ----------------------------------------------------------------------------
module point_segment_distance_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [psd_pkg::CoordBits-1:0]      in_point_x,
  input  wire  [psd_pkg::CoordBits-1:0]      in_point_y,
  input  wire  [psd_pkg::CoordBits-1:0]      in_start_x,
  input  wire  [psd_pkg::CoordBits-1:0]      in_start_y,
  input  wire  [psd_pkg::CoordBits-1:0]      in_end_x,
  input  wire  [psd_pkg::CoordBits-1:0]      in_end_y,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [psd_pkg::DistBits-1:0]       out_distance
);

  localparam int DB = psd_pkg::DiffBits;
  localparam int MB = psd_pkg::MagBits;
  localparam int PB = psd_pkg::ProdBits;
  localparam int SB = psd_pkg::SumBits;
  localparam int NB = psd_pkg::NumBits;
  localparam int TB = psd_pkg::TBits;
  localparam int OB = psd_pkg::OffBits;
  localparam int QB = psd_pkg::SqBits;
  localparam int RB = psd_pkg::RootBits;
  localparam int FB = psd_pkg::FracBits;

  logic en;
  logic out_valid_r;

  // The pipe moves whenever the last stage is empty or being drained.
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;

  // Stage 1: differences.
  logic                 s1_v_r;
  logic signed [DB-1:0] s1_dx_r, s1_dy_r, s1_rx_r, s1_ry_r, s1_bx_r, s1_by_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
    if (en) begin
      s1_dx_r <= DB'($signed(in_end_x)) - DB'($signed(in_start_x));
      s1_dy_r <= DB'($signed(in_end_y)) - DB'($signed(in_start_y));
      s1_rx_r <= DB'($signed(in_start_x)) - DB'($signed(in_point_x));
      s1_ry_r <= DB'($signed(in_start_y)) - DB'($signed(in_point_y));
      s1_bx_r <= DB'($signed(in_end_x)) - DB'($signed(in_point_x));
      s1_by_r <= DB'($signed(in_end_y)) - DB'($signed(in_point_y));
    end
  end

  function automatic logic [MB-1:0] mag_of(input logic signed [DB-1:0] v);
    logic [DB-1:0] m;
    m = v[DB-1] ? DB'(-v) : DB'(v);
    return m[MB-1:0];
  endfunction

  // Stage 2: squared length and the two dot product terms.
  logic                 s2_v_r;
  logic [PB-1:0]        s2_lx_r, s2_ly_r, s2_p1_r, s2_p2_r;
  logic                 s2_neg1_r, s2_neg2_r, s2_zero_r;
  logic signed [DB-1:0] s2_dx_r, s2_dy_r, s2_rx_r, s2_ry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
    if (en) begin
      s2_lx_r   <= PB'(mag_of(s1_dx_r)) * PB'(mag_of(s1_dx_r));
      s2_ly_r   <= PB'(mag_of(s1_dy_r)) * PB'(mag_of(s1_dy_r));
      s2_p1_r   <= PB'(mag_of(s1_rx_r)) * PB'(mag_of(s1_dx_r));
      s2_p2_r   <= PB'(mag_of(s1_ry_r)) * PB'(mag_of(s1_dy_r));
      s2_neg1_r <= s1_rx_r[DB-1] != s1_dx_r[DB-1];
      s2_neg2_r <= s1_ry_r[DB-1] != s1_dy_r[DB-1];
      s2_zero_r <= (s1_dx_r == '0) && (s1_dy_r == '0);
      // A zero-length segment measures to the second end point.
      if ((s1_dx_r == '0) && (s1_dy_r == '0)) begin
        s2_rx_r <= s1_bx_r;
        s2_ry_r <= s1_by_r;
      end else begin
        s2_rx_r <= s1_rx_r;
        s2_ry_r <= s1_ry_r;
      end
      s2_dx_r <= s1_dx_r;
      s2_dy_r <= s1_dy_r;
    end
  end

  // Stage 3: numerator, clamp decisions and the divider entry beat.
  logic signed [NB:0] num_s;
  logic [SB-1:0]      len_sq;
  psd_pkg::div_beat_t div_in;

  always_comb begin
    num_s  = (s2_neg1_r ? $signed((NB+1)'(s2_p1_r)) : -$signed((NB+1)'(s2_p1_r)))
           + (s2_neg2_r ? $signed((NB+1)'(s2_p2_r)) : -$signed((NB+1)'(s2_p2_r)));
    len_sq = SB'(s2_lx_r) + SB'(s2_ly_r);
    div_in       = '0;
    div_in.valid = s2_v_r;
    div_in.den   = len_sq;
    div_in.rx    = s2_rx_r;
    div_in.ry    = s2_ry_r;
    div_in.dx    = s2_dx_r;
    div_in.dy    = s2_dy_r;
    if (s2_zero_r || num_s <= 0) begin
      div_in.rem = '0;
      div_in.quo = '0;
    end else if (NB'(num_s) >= NB'(len_sq)) begin
      // Fraction one: a zero remainder keeps every cell bit at zero.
      div_in.rem = '0;
      div_in.quo = TB'(1);
    end else begin
      div_in.rem = NB'(num_s);
      div_in.quo = '0;
    end
    if (s2_zero_r) begin
      div_in.dx = '0;
      div_in.dy = '0;
    end
  end

  psd_pkg::div_beat_t s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s3_r.valid <= div_in.valid;
    end
    if (en) begin
      s3_r.rem <= div_in.rem;
      s3_r.den <= div_in.den;
      s3_r.quo <= div_in.quo;
      s3_r.rx  <= div_in.rx;
      s3_r.ry  <= div_in.ry;
      s3_r.dx  <= div_in.dx;
      s3_r.dy  <= div_in.dy;
    end
  end

  // Divider row.
  psd_pkg::div_beat_t div_chain [FB+1];
  assign div_chain[0] = s3_r;

  genvar gi;
  generate
    for (gi = 0; gi < FB; gi++) begin : g_div
      psd_div_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (div_chain[gi]),
        .dout (div_chain[gi+1])
      );
    end
  endgenerate

  psd_pkg::div_beat_t dq;
  assign dq = div_chain[FB];

  // Stage 4: fraction times direction.
  logic                 s4_v_r;
  logic [PB+1:0]        s4_mx_r, s4_my_r;
  logic                 s4_nx_r, s4_ny_r;
  logic signed [DB-1:0] s4_rx_r, s4_ry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= dq.valid;
    end
    if (en) begin
      s4_mx_r <= (PB+2)'(dq.quo) * (PB+2)'(mag_of(dq.dx));
      s4_my_r <= (PB+2)'(dq.quo) * (PB+2)'(mag_of(dq.dy));
      s4_nx_r <= dq.dx[DB-1];
      s4_ny_r <= dq.dy[DB-1];
      s4_rx_r <= dq.rx;
      s4_ry_r <= dq.ry;
    end
  end

  // Stage 5: offset to the nearest point.
  logic                 s5_v_r;
  logic signed [OB-1:0] s5_ox_r, s5_oy_r;
  logic signed [OB-1:0] ax_s, ay_s;

  always_comb begin
    ax_s = $signed(OB'(s4_mx_r[PB+1:FB]));
    ay_s = $signed(OB'(s4_my_r[PB+1:FB]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
    if (en) begin
      s5_ox_r <= s4_nx_r ? OB'(s4_rx_r) - ax_s : OB'(s4_rx_r) + ax_s;
      s5_oy_r <= s4_ny_r ? OB'(s4_ry_r) - ay_s : OB'(s4_ry_r) + ay_s;
    end
  end

  // Stage 6: squared distance.
  psd_pkg::sqrt_beat_t s6_r;
  logic [OB-1:0] omx, omy;

  always_comb begin
    omx = s5_ox_r[OB-1] ? OB'(-s5_ox_r) : OB'(s5_ox_r);
    omy = s5_oy_r[OB-1] ? OB'(-s5_oy_r) : OB'(s5_oy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_r.valid <= 1'b0;
    end else if (en) begin
      s6_r.valid <= s5_v_r;
    end
    if (en) begin
      s6_r.rad  <= QB'(QB'(omx) * QB'(omx)) + QB'(QB'(omy) * QB'(omy));
      s6_r.rem  <= '0;
      s6_r.root <= '0;
    end
  end

  // Square root row.
  psd_pkg::sqrt_beat_t sq_chain [RB+1];
  assign sq_chain[0] = s6_r;

  generate
    for (gi = 0; gi < RB; gi++) begin : g_sqrt
      psd_sqrt_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (sq_chain[gi]),
        .dout (sq_chain[gi+1])
      );
    end
  endgenerate

  // Output register with saturation.
  logic [psd_pkg::DistBits-1:0] out_distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_chain[RB].valid;
    end
    if (en) begin
      if (sq_chain[RB].root[RB-1:psd_pkg::DistBits] != '0) begin
        out_distance_r <= '1;
      end else begin
        out_distance_r <= sq_chain[RB].root[psd_pkg::DistBits-1:0];
      end
    end
  end

  assign out_distance = out_distance_r;

endmodule
`default_nettype wire
